// File: rtl/core/mtcqf_pkg.sv
// ----------------------------------------------------------------------------
// mtcqf_pkg
// shared widths, rate codes and frame-to-millisecond tables for the
// quarter-frame assembler
// ----------------------------------------------------------------------------
package mtcqf_pkg;

    localparam int unsigned SLOT_COUNT = 8;
    localparam int unsigned SLOT_W     = 3;
    localparam int unsigned NIB_W      = 4;
    localparam int unsigned MS_W       = 27;
    localparam int unsigned FMS_W      = 11;

    // rate codes carried in nibble 7 bits 2-1
    localparam logic [1:0] RATE_24    = 2'd0;
    localparam logic [1:0] RATE_25    = 2'd1;
    localparam logic [1:0] RATE_30_DF = 2'd2;
    localparam logic [1:0] RATE_30    = 2'd3;

    localparam logic [MS_W-1:0] MS_PER_HOUR = MS_W'(3600000);
    localparam logic [MS_W-1:0] MS_PER_MIN  = MS_W'(60000);
    localparam logic [MS_W-1:0] MS_PER_SEC  = MS_W'(1000);
    localparam logic [FMS_W-1:0] MS_PER_FRAME_25 = FMS_W'(40);

    typedef logic [NIB_W-1:0] t_nibble;

    // floor(f * 1000 / 24)
    localparam logic [FMS_W-1:0] FMS_24 [0:31] = '{
        11'd0,    11'd41,   11'd83,   11'd125,  11'd166,  11'd208,  11'd250,  11'd291,
        11'd333,  11'd375,  11'd416,  11'd458,  11'd500,  11'd541,  11'd583,  11'd625,
        11'd666,  11'd708,  11'd750,  11'd791,  11'd833,  11'd875,  11'd916,  11'd958,
        11'd1000, 11'd1041, 11'd1083, 11'd1125, 11'd1166, 11'd1208, 11'd1250, 11'd1291
    };

    // floor(f * 1000 / 30)
    localparam logic [FMS_W-1:0] FMS_30 [0:31] = '{
        11'd0,    11'd33,   11'd66,   11'd100,  11'd133,  11'd166,  11'd200,  11'd233,
        11'd266,  11'd300,  11'd333,  11'd366,  11'd400,  11'd433,  11'd466,  11'd500,
        11'd533,  11'd566,  11'd600,  11'd633,  11'd666,  11'd700,  11'd733,  11'd766,
        11'd800,  11'd833,  11'd866,  11'd900,  11'd933,  11'd966,  11'd1000, 11'd1033
    };

    // frame count to milliseconds, truncated, per rate code
    function automatic logic [FMS_W-1:0] frame_ms(input logic [4:0] frames,
                                                  input logic [1:0] rate);
        logic [FMS_W-1:0] v;
        case (rate)
            RATE_24: v = FMS_24[frames];
            RATE_25: v = FMS_W'(frames) * MS_PER_FRAME_25;
            default: v = FMS_30[frames];
        endcase
        return v;
    endfunction

    // full timecode to milliseconds
    function automatic logic [MS_W-1:0] tc_to_ms(input logic [4:0] hours,
                                                 input logic [5:0] minutes,
                                                 input logic [5:0] seconds,
                                                 input logic [4:0] frames,
                                                 input logic [1:0] rate);
        return MS_W'(hours) * MS_PER_HOUR + MS_W'(minutes) * MS_PER_MIN
             + MS_W'(seconds) * MS_PER_SEC + MS_W'(frame_ms(frames, rate));
    endfunction

endpackage

// File: rtl/core/mtcqf_ms_calc.sv
// ----------------------------------------------------------------------------
// mtcqf_ms_calc
// converts an assembled timecode to milliseconds with constant multipliers
// and a per-rate frame table, or a multiply by 40 at 25 fps
// ----------------------------------------------------------------------------
module mtcqf_ms_calc
    import mtcqf_pkg::*;
(
    input  logic [4:0]      i_hours,
    input  logic [5:0]      i_minutes,
    input  logic [5:0]      i_seconds,
    input  logic [4:0]      i_frames,
    input  logic [1:0]      i_rate,
    output logic [MS_W-1:0] o_ms
);

    logic [MS_W-1:0] hm_ms;
    logic [MS_W-1:0] sf_ms;

    // hours and minutes, seconds and frames as two partial sums
    assign hm_ms = MS_W'(i_hours) * MS_PER_HOUR + MS_W'(i_minutes) * MS_PER_MIN;
    assign sf_ms = MS_W'(i_seconds) * MS_PER_SEC + MS_W'(frame_ms(i_frames, i_rate));
    assign o_ms  = hm_ms + sf_ms;

endmodule

// File: rtl/core/mtc_quarter_frame_assembler_unit.sv
// ----------------------------------------------------------------------------
// mtc_quarter_frame_assembler_unit
// assembles midi time code quarter-frame bytes into a full timecode
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall carry one quarter-frame data byte per
//   item on i_qf_byte. bit 7 set means the item is dropped with no effect.
//   otherwise bits 6-4 pick a slot and bits 3-0 are stored there.
//   output channel: o_valid / i_stall carry one timecode item each time all
//   eight slots have been received; the slot store is then cleared.
//   throughput: one input item per cycle, sustained, as long as the
//   receiver takes results; the store update, field assembly and the
//   millisecond conversion each fit in one register-to-register pass.
//   order: the assembly register loads when the completing item is
//   accepted, and the result register takes the fields with the
//   millisecond sum once it is free or its result is taken.
//   stall: a held result stays stable on the output; one more completed
//   timecode can wait in the assembly register, and o_stall only rises
//   when both registers are full and the receiver still stalls.
//   reset: synchronous, active low; clears the slot store, the received
//   mask and both valid flags. no clearing sweep is needed.
// ----------------------------------------------------------------------------
module mtc_quarter_frame_assembler_unit
    import mtcqf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // quarter-frame byte channel
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_qf_byte,
    // timecode result channel
    output logic            o_valid,
    input  logic            i_stall,
    output logic [4:0]      o_tc_hours,
    output logic [5:0]      o_tc_minutes,
    output logic [5:0]      o_tc_seconds,
    output logic [4:0]      o_tc_frames,
    output logic [1:0]      o_rate_code,
    output logic [MS_W-1:0] o_total_ms
);

    // slot store and received mask
    t_nibble               r_store [SLOT_COUNT];
    t_nibble               n_store [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_seen;
    logic [SLOT_COUNT-1:0] n_seen;

    // assembly register
    logic       r_s1_valid;
    logic [4:0] r_s1_hours;
    logic [5:0] r_s1_minutes;
    logic [5:0] r_s1_seconds;
    logic [4:0] r_s1_frames;
    logic [1:0] r_s1_rate;

    // result register
    logic            r_out_valid;
    logic [4:0]      r_out_hours;
    logic [5:0]      r_out_minutes;
    logic [5:0]      r_out_seconds;
    logic [4:0]      r_out_frames;
    logic [1:0]      r_out_rate;
    logic [MS_W-1:0] r_out_ms;

    logic              in_take;
    logic              is_data;
    logic [SLOT_W-1:0] slot;
    logic              complete;
    logic              s1_move;
    logic [MS_W-1:0]   calc_ms;

    // the assembly register can move on when the result register is free or being taken
    assign s1_move = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_move;
    assign in_take = i_valid && !o_stall;

    assign is_data = !i_qf_byte[7];
    assign slot    = i_qf_byte[6:4];

    // store with the incoming nibble merged in
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            n_store[i] = r_store[i];
        end
        n_store[slot] = i_qf_byte[NIB_W-1:0];
        n_seen        = r_seen | (SLOT_COUNT'(1) << slot);
    end

    assign complete = in_take && is_data && (n_seen == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_store[i] <= '0;
            end
            r_seen      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // slot store: write, or clear once the set is complete
            if (in_take && is_data) begin
                if (complete) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        r_store[i] <= '0;
                    end
                    r_seen <= '0;
                end else begin
                    r_store <= n_store;
                    r_seen  <= n_seen;
                end
            end

            // assembly register, fields masked per the mtc layout
            if (complete) begin
                r_s1_valid   <= 1'b1;
                r_s1_frames  <= {n_store[1][0],   n_store[0]};
                r_s1_seconds <= {n_store[3][1:0], n_store[2]};
                r_s1_minutes <= {n_store[5][1:0], n_store[4]};
                r_s1_hours   <= {n_store[7][0],   n_store[6]};
                r_s1_rate    <= n_store[7][2:1];
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            // result register with the millisecond sum
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_out_hours   <= r_s1_hours;
                    r_out_minutes <= r_s1_minutes;
                    r_out_seconds <= r_s1_seconds;
                    r_out_frames  <= r_s1_frames;
                    r_out_rate    <= r_s1_rate;
                    r_out_ms      <= calc_ms;
                end
            end
        end
    end

    mtcqf_ms_calc u_ms_calc (
        .i_hours   (r_s1_hours),
        .i_minutes (r_s1_minutes),
        .i_seconds (r_s1_seconds),
        .i_frames  (r_s1_frames),
        .i_rate    (r_s1_rate),
        .o_ms      (calc_ms)
    );

    assign o_valid      = r_out_valid;
    assign o_tc_hours   = r_out_hours;
    assign o_tc_minutes = r_out_minutes;
    assign o_tc_seconds = r_out_seconds;
    assign o_tc_frames  = r_out_frames;
    assign o_rate_code  = r_out_rate;
    assign o_total_ms   = r_out_ms;

endmodule

// File: rtl/core/mtcqf_checker.sv
// ----------------------------------------------------------------------------
// mtcqf_checker
// port-level checks for the quarter-frame assembler, bound to the top level
// ----------------------------------------------------------------------------
module mtcqf_checker
    import mtcqf_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic [7:0]      i_qf_byte,
    input logic            o_valid,
    input logic            i_stall,
    input logic [4:0]      o_tc_hours,
    input logic [5:0]      o_tc_minutes,
    input logic [5:0]      o_tc_seconds,
    input logic [4:0]      o_tc_frames,
    input logic [1:0]      o_rate_code,
    input logic [MS_W-1:0] o_total_ms
);

    // a held result stays valid, with its milliseconds and frames stable on the port
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_total_ms) && $stable(o_tc_frames))
        else $error("stalled result changed");

    // milliseconds agree with the fields shown beside them
    a_ms_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_total_ms == tc_to_ms(o_tc_hours, o_tc_minutes, o_tc_seconds,
                                           o_tc_frames, o_rate_code))
        else $error("total_ms does not match timecode fields");

    // input back-pressure only while a result is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind mtc_quarter_frame_assembler_unit mtcqf_checker u_mtcqf_checker (.*);
